// ===== rtl/mwsm_pkg.sv =====
// Package of the mecanum wheel speed mixer: register codes, limit widths, reset value.
// No dependencies; used by the configuration interface and the core.
`default_nettype none

package mwsm_pkg;

  localparam int LIMIT_WIDTH     = 15;
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int QUOT_WIDTH      = 15;
  localparam int NUM_WHEELS      = 4;

  typedef logic [LIMIT_WIDTH-1:0] limit_t;

  localparam limit_t LIMIT_RESET = 15'd8000;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_LIMIT_X,
    REG_LIMIT_Y,
    REG_LIMIT_ROT,
    REG_WHEEL_LIMIT
  } cfg_reg_t;

endpackage

`default_nettype wire

// ===== rtl/mwsm_cmd_if.sv =====
// Chassis velocity command channel (valid/ready, one item per handshake).
// Depends on nothing; width set by SPEED_WIDTH.
`default_nettype none

interface mwsm_cmd_if #(
  parameter int SPEED_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SPEED_WIDTH-1:0] vel_x;
  logic signed [SPEED_WIDTH-1:0] vel_y;
  logic signed [SPEED_WIDTH-1:0] vel_rot;

  modport source (output valid, output vel_x, output vel_y, output vel_rot, input ready);
  modport sink   (input valid, input vel_x, input vel_y, input vel_rot, output ready);
endinterface

`default_nettype wire

// ===== rtl/mwsm_wheel_if.sv =====
// Wheel speed result channel (valid/ready, four wheel speeds per item).
// Depends on nothing; width set by SPEED_WIDTH.
`default_nettype none

interface mwsm_wheel_if #(
  parameter int SPEED_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SPEED_WIDTH-1:0] wheel_0;
  logic signed [SPEED_WIDTH-1:0] wheel_1;
  logic signed [SPEED_WIDTH-1:0] wheel_2;
  logic signed [SPEED_WIDTH-1:0] wheel_3;

  modport source (output valid, output wheel_0, output wheel_1, output wheel_2,
                  output wheel_3, input ready);
  modport sink   (input valid, input wheel_0, input wheel_1, input wheel_2,
                  input wheel_3, output ready);
endinterface

`default_nettype wire

// ===== rtl/mwsm_cfg_if.sv =====
// Configuration write channel: register index and write data, valid/ready.
// Depends on mwsm_pkg.
`default_nettype none

interface mwsm_cfg_if;
  logic                      valid;
  logic                      ready;
  mwsm_pkg::cfg_reg_t        index;
  logic [mwsm_pkg::LIMIT_WIDTH-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/mecanum_wheel_speed_mixer_core.sv =====
// Mecanum wheel speed mixer: clamp, mix, peak search, multiply and pipelined divide.
// Depends on mwsm_pkg, mwsm_cmd_if, mwsm_wheel_if, mwsm_cfg_if.
//
// Takes one x/y/rotation command per item, clamps each part to its limit, mixes it into
// four wheel speeds and, when the largest magnitude exceeds wheel_limit, scales all four
// by wheel_limit / peak with truncation toward zero. Fully pipelined: one item can enter
// every cycle while no output stall holds the pipeline, and each item passes through 20
// register stages (clamp, mix, magnitude, peak and multiply, 15 restoring divide stages of
// one quotient bit each, output register). Most of the stages form the divide chain.
// Stalls on the output side back-pressure stage by stage, so empty stages still accept.
// Configuration writes are always accepted and must only be made while no item is in
// flight.
`default_nettype none

module mecanum_wheel_speed_mixer_core #(
  parameter int SPEED_WIDTH = 16
) (
  input  wire                 clk,
  input  wire                 rst_n,
  mwsm_cmd_if.sink            in_cmd,
  mwsm_wheel_if.source        out_wheel,
  mwsm_cfg_if.sink            cfg_wr
);

  localparam int LW   = mwsm_pkg::LIMIT_WIDTH;
  localparam int QW   = mwsm_pkg::QUOT_WIDTH;
  localparam int NW   = mwsm_pkg::NUM_WHEELS;
  localparam int SUMW = SPEED_WIDTH + 2;
  localparam int MW   = SPEED_WIDTH + 1;
  localparam int PW   = MW + LW;
  localparam int EW   = SPEED_WIDTH + 17;

  typedef struct packed {
    logic [NW-1:0]          sign;
    logic [NW-1:0][MW-1:0]  mag;
    logic [NW-1:0][PW-1:0]  rem;
    logic [NW-1:0][QW-1:0]  quo;
    logic [MW-1:0]          peak;
    logic                   scale;
  } div_t;

  // configuration registers
  mwsm_pkg::limit_t limit_x_r, limit_y_r, limit_rot_r, wheel_limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_x_r     <= mwsm_pkg::LIMIT_RESET;
      limit_y_r     <= mwsm_pkg::LIMIT_RESET;
      limit_rot_r   <= mwsm_pkg::LIMIT_RESET;
      wheel_limit_r <= mwsm_pkg::LIMIT_RESET;
    end else if (cfg_wr.valid) begin
      case (cfg_wr.index)
        mwsm_pkg::REG_LIMIT_X:     limit_x_r     <= cfg_wr.data;
        mwsm_pkg::REG_LIMIT_Y:     limit_y_r     <= cfg_wr.data;
        mwsm_pkg::REG_LIMIT_ROT:   limit_rot_r   <= cfg_wr.data;
        mwsm_pkg::REG_WHEEL_LIMIT: wheel_limit_r <= cfg_wr.data;
        default: ;
      endcase
    end
  end

  assign cfg_wr.ready = 1'b1;

  function automatic logic signed [SPEED_WIDTH-1:0] clamp_sym(
    input logic signed [SPEED_WIDTH-1:0] v,
    input logic [LW-1:0]                 lim
  );
    logic signed [EW-1:0] ve;
    logic signed [EW-1:0] le;
    logic signed [EW-1:0] res;
    ve = EW'(v);
    le = signed'(EW'(lim));
    if (ve > le) begin
      res = le;
    end else if (ve < -le) begin
      res = -le;
    end else begin
      res = ve;
    end
    return res[SPEED_WIDTH-1:0];
  endfunction

  // pipeline registers
  logic                          a_v_r, b_v_r, c_v_r, out_v_r;
  logic signed [SPEED_WIDTH-1:0] a_x_r, a_y_r, a_w_r;
  logic signed [SUMW-1:0]        b_s_r [NW];
  logic [NW-1:0]                 c_sign_r;
  logic [MW-1:0]                 c_mag_r [NW];
  logic [QW:0]                   dv_r;
  div_t                          div_r   [QW+1];
  div_t                          div_nxt [QW+1];
  logic [SPEED_WIDTH-1:0]        out_w_r   [NW];
  logic [SPEED_WIDTH-1:0]        out_w_nxt [NW];

  logic          a_load, b_load, c_load, out_load;
  logic [QW:0]   d_load;

  // per-stage load enables, bubbles collapse
  always_comb begin
    out_load   = !out_v_r || out_wheel.ready;
    d_load[QW] = !dv_r[QW] || out_load;
    for (int k = QW - 1; k >= 0; k--) begin
      d_load[k] = !dv_r[k] || d_load[k+1];
    end
    c_load = !c_v_r || d_load[0];
    b_load = !b_v_r || c_load;
    a_load = !a_v_r || b_load;
  end

  assign in_cmd.ready = a_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r   <= 1'b0;
      b_v_r   <= 1'b0;
      c_v_r   <= 1'b0;
      dv_r    <= '0;
      out_v_r <= 1'b0;
    end else begin
      if (a_load)    a_v_r   <= in_cmd.valid;
      if (b_load)    b_v_r   <= a_v_r;
      if (c_load)    c_v_r   <= b_v_r;
      if (d_load[0]) dv_r[0] <= c_v_r;
      for (int k = 0; k < QW; k++) begin
        if (d_load[k+1]) dv_r[k+1] <= dv_r[k];
      end
      if (out_load)  out_v_r <= dv_r[QW];
    end
  end

  // stage A: clamp
  always_ff @(posedge clk) begin
    if (a_load) begin
      a_x_r <= clamp_sym(in_cmd.vel_x,   limit_x_r);
      a_y_r <= clamp_sym(in_cmd.vel_y,   limit_y_r);
      a_w_r <= clamp_sym(in_cmd.vel_rot, limit_rot_r);
    end
  end

  // stage B: mix
  always_ff @(posedge clk) begin
    if (b_load) begin
      b_s_r[0] <=  SUMW'(a_x_r) - SUMW'(a_y_r) + SUMW'(a_w_r);
      b_s_r[1] <=  SUMW'(a_x_r) + SUMW'(a_y_r) + SUMW'(a_w_r);
      b_s_r[2] <= -SUMW'(a_x_r) + SUMW'(a_y_r) + SUMW'(a_w_r);
      b_s_r[3] <= -SUMW'(a_x_r) - SUMW'(a_y_r) + SUMW'(a_w_r);
    end
  end

  // stage C: sign and magnitude
  always_ff @(posedge clk) begin
    if (c_load) begin
      for (int i = 0; i < NW; i++) begin
        c_sign_r[i] <= b_s_r[i][SUMW-1];
        c_mag_r[i]  <= b_s_r[i][SUMW-1] ? MW'(-b_s_r[i]) : MW'(b_s_r[i]);
      end
    end
  end

  // stage D: peak search and dividend product
  always_comb begin
    logic [MW-1:0] p01;
    logic [MW-1:0] p23;
    p01 = (c_mag_r[0] > c_mag_r[1]) ? c_mag_r[0] : c_mag_r[1];
    p23 = (c_mag_r[2] > c_mag_r[3]) ? c_mag_r[2] : c_mag_r[3];
    div_nxt[0].peak  = (p01 > p23) ? p01 : p23;
    div_nxt[0].scale = 1'b0;
    div_nxt[0].sign  = c_sign_r;
    for (int i = 0; i < NW; i++) begin
      div_nxt[0].mag[i] = c_mag_r[i];
      div_nxt[0].rem[i] = PW'(c_mag_r[i]) * PW'(wheel_limit_r);
      div_nxt[0].quo[i] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (d_load[0]) div_r[0] <= div_nxt[0];
  end

  // restoring divide, one quotient bit per stage, MSB first
  for (genvar k = 0; k < QW; k++) begin : g_div
    localparam int B = QW - 1 - k;

    always_comb begin
      logic [PW-1:0] trial;
      div_nxt[k+1] = div_r[k];
      trial = PW'(div_r[k].peak) << B;
      if (k == 0) begin
        div_nxt[k+1].scale = PW'(div_r[k].peak) > PW'(wheel_limit_r);
      end
      for (int i = 0; i < NW; i++) begin
        if (div_r[k].rem[i] >= trial) begin
          div_nxt[k+1].rem[i]    = div_r[k].rem[i] - trial;
          div_nxt[k+1].quo[i][B] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (d_load[k+1]) div_r[k+1] <= div_nxt[k+1];
    end
  end

  // output: pick scaled or raw magnitude, restore sign
  always_comb begin
    logic [EW-1:0] m;
    logic [EW-1:0] res;
    for (int i = 0; i < NW; i++) begin
      m   = div_r[QW].scale ? EW'(div_r[QW].quo[i]) : EW'(div_r[QW].mag[i]);
      res = div_r[QW].sign[i] ? -m : m;
      out_w_nxt[i] = res[SPEED_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      for (int i = 0; i < NW; i++) begin
        out_w_r[i] <= out_w_nxt[i];
      end
    end
  end

  assign out_wheel.valid   = out_v_r;
  assign out_wheel.wheel_0 = out_w_r[0];
  assign out_wheel.wheel_1 = out_w_r[1];
  assign out_wheel.wheel_2 = out_w_r[2];
  assign out_wheel.wheel_3 = out_w_r[3];

`ifndef SYNTH
  a_peak_covers: assert property (@(posedge clk) disable iff (!rst_n)
    dv_r[0] |-> (div_r[0].mag[0] <= div_r[0].peak) && (div_r[0].mag[1] <= div_r[0].peak) &&
                (div_r[0].mag[2] <= div_r[0].peak) && (div_r[0].mag[3] <= div_r[0].peak))
    else $error("peak below a wheel magnitude");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (dv_r[QW] && div_r[QW].scale) |->
      (div_r[QW].rem[0] < PW'(div_r[QW].peak)) && (div_r[QW].rem[1] < PW'(div_r[QW].peak)) &&
      (div_r[QW].rem[2] < PW'(div_r[QW].peak)) && (div_r[QW].rem[3] < PW'(div_r[QW].peak)))
    else $error("divide remainder not below divisor");

  a_quo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (dv_r[QW] && div_r[QW].scale) |->
      (div_r[QW].quo[0] <= wheel_limit_r) && (div_r[QW].quo[1] <= wheel_limit_r) &&
      (div_r[QW].quo[2] <= wheel_limit_r) && (div_r[QW].quo[3] <= wheel_limit_r))
    else $error("scaled wheel speed above wheel limit");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_wheel.ready) |=> out_v_r && $stable(out_w_r[0]) && $stable(out_w_r[3]))
    else $error("stalled result changed");
`endif

endmodule

`default_nettype wire

// ===== bench/tb_mecanum_wheel_speed_mixer_core.sv =====
// Testbench of mecanum_wheel_speed_mixer_core: a directed command table, then random
// commands over several limit settings; items checked against table rows or a local mixer.
// Depends on mwsm_pkg, mwsm_cmd_if, mwsm_wheel_if, mwsm_cfg_if and the core.

module tb_mecanum_wheel_speed_mixer_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SW              = 16;
  localparam int NUM_REGS        = int'(mwsm_pkg::REG_WHEEL_LIMIT) + 1;
  localparam int NUM_DIRECTED    = 22;
  localparam int NUM_FIXED       = 6;
  localparam int NUM_PHASES      = 10;
  localparam int ITEMS_PER_PHASE = 72;
  localparam int IDLE_LIMIT      = 1000;
  localparam int TAIL_CYCLES     = 40;
  localparam int NUM_WHEELS      = mwsm_pkg::NUM_WHEELS;

  typedef logic signed [SW-1:0]          speed_t;
  typedef logic [NUM_WHEELS-1:0][SW-1:0] wheel_set_t;

  typedef struct packed {
    int vx;
    int vy;
    int vr;
    bit typed;
    int w0;
    int w1;
    int w2;
    int w3;
  } vec_row_t;

  // vx, vy, vr, typed, wheel_0..wheel_3 (reset limits: 8000 everywhere)
  vec_row_t directed_rows [NUM_DIRECTED] = '{
    '{0, 0, 0, 1'b1, 0, 0, 0, 0},
    '{32767, 0, 0, 1'b1, 8000, 8000, -8000, -8000},
    '{-32768, 0, 0, 1'b1, -8000, -8000, 8000, 8000},
    '{0, 32767, 0, 1'b1, -8000, 8000, 8000, -8000},
    '{0, -32768, 0, 1'b1, 8000, -8000, -8000, 8000},
    '{0, 0, 32767, 1'b1, 8000, 8000, 8000, 8000},
    '{0, 0, -32768, 1'b1, -8000, -8000, -8000, -8000},
    '{32767, 32767, 32767, 1'b1, 2666, 8000, 2666, -2666},
    '{-32768, -32768, -32768, 1'b1, -2666, -8000, -2666, 2666},
    '{32767, -32768, 32767, 1'b1, 8000, 2666, -2666, 2666},
    '{4000, 4000, 0, 1'b1, 0, 8000, 0, -8000},
    '{4000, 4000, 1, 1'b0, 0, 0, 0, 0},
    '{8000, 0, 0, 1'b1, 8000, 8000, -8000, -8000},
    '{8001, 0, 0, 1'b1, 8000, 8000, -8000, -8000},
    '{-8001, 0, 0, 1'b1, -8000, -8000, 8000, 8000},
    '{1, -1, 1, 1'b0, 0, 0, 0, 0},
    '{-1, -1, -1, 1'b0, 0, 0, 0, 0},
    '{21845, -21846, 21845, 1'b0, 0, 0, 0, 0},
    '{-21846, 21845, -21846, 1'b0, 0, 0, 0, 0},
    '{123, -4567, 2345, 1'b0, 0, 0, 0, 0},
    '{3000, -2000, 7000, 1'b0, 0, 0, 0, 0},
    '{-5000, 2500, -6000, 1'b0, 0, 0, 0, 0}
  };

  // limit_x, limit_y, limit_rotation, wheel_limit
  int fixed_cfg [NUM_FIXED][NUM_REGS] = '{
    '{0, 0, 0, 1},
    '{32767, 32767, 32767, 32767},
    '{32767, 32767, 32767, 1},
    '{32767, 32767, 32767, 0},
    '{0, 12000, 32767, 20000},
    '{5000, 0, 3000, 6000}
  };

  logic clk;
  logic rst_n;

  mwsm_cmd_if   #(.SPEED_WIDTH(SW)) cmd_ch ();
  mwsm_wheel_if #(.SPEED_WIDTH(SW)) wheel_ch ();
  mwsm_cfg_if                       cfg_ch ();

  mecanum_wheel_speed_mixer_core #(.SPEED_WIDTH(SW)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_cmd   (cmd_ch),
    .out_wheel(wheel_ch),
    .cfg_wr   (cfg_ch)
  );

  mwsm_pkg::limit_t reg_shadow [NUM_REGS];
  wheel_set_t       wheel_q [$];
  bit               pend_typed;
  wheel_set_t       pend_exp;
  bit               gaps_on;
  bit               stall_on;
  int               burst_left;
  int               fail_cnt    = 0;
  int               idle_cycles = 0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic longint clip(speed_t v, mwsm_pkg::limit_t lim);
    longint l;
    l = longint'(lim);
    if (longint'(v) > l) return l;
    if (longint'(v) < -l) return -l;
    return longint'(v);
  endfunction

  function automatic wheel_set_t mix_wheels(speed_t vx, speed_t vy, speed_t vr);
    longint x, y, w, wl, peak, mag;
    longint s [NUM_WHEELS];
    wheel_set_t res;
    x  = clip(vx, reg_shadow[mwsm_pkg::REG_LIMIT_X]);
    y  = clip(vy, reg_shadow[mwsm_pkg::REG_LIMIT_Y]);
    w  = clip(vr, reg_shadow[mwsm_pkg::REG_LIMIT_ROT]);
    wl = longint'(reg_shadow[mwsm_pkg::REG_WHEEL_LIMIT]);
    s[0] = x - y + w;
    s[1] = x + y + w;
    s[2] = -x + y + w;
    s[3] = -x - y + w;
    peak = 0;
    for (int i = 0; i < NUM_WHEELS; i++) begin
      mag = (s[i] < 0) ? -s[i] : s[i];
      if (mag > peak) peak = mag;
    end
    for (int i = 0; i < NUM_WHEELS; i++) begin
      if (peak > wl) s[i] = (s[i] * wl) / peak;
      res[i] = s[i][SW-1:0];
    end
    return res;
  endfunction

  function automatic speed_t pick_speed(mwsm_pkg::limit_t lim);
    int l;
    int v;
    l = int'(lim);
    case ($urandom_range(0, 9))
      0, 1, 2: v = int'($urandom_range(0, 65535)) - 32768;
      3, 4, 5: v = int'($urandom_range(0, 2 * l)) - l;
      6:       v = l + int'($urandom_range(0, 2)) - 1;
      7:       v = -(l + int'($urandom_range(0, 2)) - 1);
      8: begin
        case ($urandom_range(0, 4))
          0:       v = 32767;
          1:       v = -32768;
          2:       v = 1;
          3:       v = -1;
          default: v = 0;
        endcase
      end
      default: v = int'($urandom_range(0, 64)) - 32;
    endcase
    return speed_t'(v);
  endfunction

  always @(posedge clk) begin
    wheel_set_t got;
    wheel_set_t want;
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) reg_shadow[cfg_ch.index] = cfg_ch.data;
      if (cmd_ch.valid && cmd_ch.ready) begin
        wheel_q.push_back(pend_typed ? pend_exp
                                     : mix_wheels(cmd_ch.vel_x, cmd_ch.vel_y, cmd_ch.vel_rot));
      end
      if (wheel_ch.valid && wheel_ch.ready) begin
        got = {wheel_ch.wheel_3, wheel_ch.wheel_2, wheel_ch.wheel_1, wheel_ch.wheel_0};
        if (wheel_q.size() == 0) begin
          $error("wheel item with no command pending");
          fail_cnt++;
        end else begin
          want = wheel_q.pop_front();
          for (int i = 0; i < NUM_WHEELS; i++) begin
            if (got[i] !== want[i]) begin
              $error("wheel_%0d: expected %0d, got %0d", i, $signed(want[i]), $signed(got[i]));
              fail_cnt++;
            end
          end
        end
      end
      if ((cmd_ch.valid && cmd_ch.ready) || (wheel_ch.valid && wheel_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_mecanum_wheel_speed_mixer_core: FAIL");
        $finish;
      end
    end
  end

  // receiver back-pressure
  initial begin
    int stall_left;
    stall_left = 0;
    wheel_ch.ready = 1'b1;
    forever begin
      @(negedge clk);
      if (stall_on && stall_left == 0 && $urandom_range(0, 3) == 0)
        stall_left = $urandom_range(1, 8);
      if (stall_left > 0) begin
        wheel_ch.ready = 1'b0;
        stall_left--;
      end else begin
        wheel_ch.ready = 1'b1;
      end
    end
  end

  task automatic idle_cmd(int n);
    repeat (n) begin
      @(negedge clk);
      cmd_ch.valid = 1'b0;
    end
  endtask

  task automatic send_cmd(speed_t vx, speed_t vy, speed_t vr, bit typed, wheel_set_t exp);
    @(negedge clk);
    cmd_ch.valid   = 1'b1;
    cmd_ch.vel_x   = vx;
    cmd_ch.vel_y   = vy;
    cmd_ch.vel_rot = vr;
    pend_typed     = typed;
    pend_exp       = exp;
    do @(posedge clk); while (!cmd_ch.ready);
    if (gaps_on) begin
      if (burst_left == 0) begin
        idle_cmd($urandom_range(1, ($urandom_range(0, 7) == 0) ? 30 : 5));
        burst_left = $urandom_range(1, 12);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic drain_wheels();
    idle_cmd(1);
    while (wheel_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(mwsm_pkg::cfg_reg_t idx, mwsm_pkg::limit_t val);
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = val;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  initial begin
    vec_row_t         row;
    wheel_set_t       exp;
    mwsm_pkg::limit_t cfg_set [NUM_REGS];
    rst_n          = 1'b0;
    cmd_ch.valid   = 1'b0;
    cmd_ch.vel_x   = '0;
    cmd_ch.vel_y   = '0;
    cmd_ch.vel_rot = '0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.index   = mwsm_pkg::REG_LIMIT_X;
    cfg_ch.data    = '0;
    pend_typed     = 1'b0;
    pend_exp       = '0;
    gaps_on        = 1'b0;
    stall_on       = 1'b0;
    burst_left     = 0;
    for (int r = 0; r < NUM_REGS; r++) reg_shadow[r] = mwsm_pkg::LIMIT_RESET;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      exp = {speed_t'(row.w3), speed_t'(row.w2), speed_t'(row.w1), speed_t'(row.w0)};
      send_cmd(speed_t'(row.vx), speed_t'(row.vy), speed_t'(row.vr), row.typed, exp);
    end
    drain_wheels();

    for (int p = 0; p < NUM_PHASES; p++) begin
      for (int r = 0; r < NUM_REGS; r++) begin
        cfg_set[r] = (p < NUM_FIXED) ? mwsm_pkg::limit_t'(fixed_cfg[p][r])
                                     : mwsm_pkg::limit_t'($urandom_range(0, 32767));
        write_reg(mwsm_pkg::cfg_reg_t'(r), cfg_set[r]);
      end
      gaps_on  = (p % 5 != 0);
      stall_on = (p % 5 != 0) && (p % 3 != 1);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        send_cmd(pick_speed(cfg_set[mwsm_pkg::REG_LIMIT_X]),
                 pick_speed(cfg_set[mwsm_pkg::REG_LIMIT_Y]),
                 pick_speed(cfg_set[mwsm_pkg::REG_LIMIT_ROT]), 1'b0, '0);
        if (k == ITEMS_PER_PHASE / 2) drain_wheels();
      end
      drain_wheels();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("tb_mecanum_wheel_speed_mixer_core: PASS");
    end else begin
      $display("tb_mecanum_wheel_speed_mixer_core: FAIL");
    end
    $finish;
  end

endmodule
